// ===== rtl/sht_pkg.sv =====
// sht_pkg: shared types, codes, constants and the hour schedule table
// for the scheduled hysteresis thermostat; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sht_pkg;

	localparam int TIMER_WIDTH_DEF    = 24;
	localparam int TEMP_FRAC_BITS_DEF = 4;

	localparam int TEMP_W     = 16;
	localparam int INTERVAL_W = 24;
	localparam int WAIT_W     = 15;
	localparam int HOUR_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int DIFF_W     = 18;
	localparam int OFFSET_W   = 5;

	localparam int BASE_DEG         = 70;
	localparam int SAFETY_DEG       = 82;
	localparam int MIN_INTERVAL_RST = 300000;
	localparam int MS_PER_S         = 1000;

	// floor(x / 1000) = (x * DIV_MUL) >> DIV_SHIFT, exact for x < 2**24
	localparam int DIV_SHIFT = 34;
	localparam int DIV_MUL_W = 25;
	localparam logic [DIV_MUL_W-1:0] DIV_MUL =
		DIV_MUL_W'(((64'd1 << DIV_SHIFT) + MS_PER_S - 1) / MS_PER_S);

	typedef enum logic [2:0] {
		MODE_TICK   = 3'd0,
		MODE_TEMP   = 3'd1,
		MODE_TOGGLE = 3'd2,
		MODE_CLEAR  = 3'd3,
		MODE_ENABLE = 3'd4
	} mode_t;

	typedef enum logic [3:0] {
		ST_NONE       = 4'd0,
		ST_TURNED_ON  = 4'd1,
		ST_TURNED_OFF = 4'd2,
		ST_NOT_EN     = 4'd3,
		ST_OVR_ON     = 4'd4,
		ST_OVR_OFF    = 4'd5,
		ST_MANUAL_ON  = 4'd6,
		ST_REFUSED    = 4'd7,
		ST_MANUAL_OFF = 4'd8
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE     = 3'd0,
		CFG_ON_MARG  = 3'd1,
		CFG_OFF_MARG = 3'd2,
		CFG_INTERVAL = 3'd3,
		CFG_SAFETY   = 3'd4
	} cfg_idx_t;

	typedef enum logic [3:0] {
		HS_OFF      = 4'b0001,
		HS_ON       = 4'b0010,
		HS_PEND_ON  = 4'b0100,
		HS_PEND_OFF = 4'b1000
	} heat_state_t;

	localparam logic [1:0] CODE_OFF      = 2'd0;
	localparam logic [1:0] CODE_ON       = 2'd1;
	localparam logic [1:0] CODE_PEND_ON  = 2'd2;
	localparam logic [1:0] CODE_PEND_OFF = 2'd3;

	function automatic logic [1:0] state_code(heat_state_t s);
		logic [1:0] c;
		c = CODE_OFF;
		unique case (s)
			HS_OFF:      c = CODE_OFF;
			HS_ON:       c = CODE_ON;
			HS_PEND_ON:  c = CODE_PEND_ON;
			HS_PEND_OFF: c = CODE_PEND_OFF;
			default:     c = CODE_OFF;
		endcase
		return c;
	endfunction

	// schedule offset in whole degrees, zero outside hours 1..24
	function automatic logic signed [OFFSET_W-1:0] hour_offset(logic [HOUR_W-1:0] h);
		logic signed [OFFSET_W-1:0] o;
		o = '0;
		case (h)
			8'd1, 8'd2, 8'd3, 8'd4:    o = -5'sd15;
			8'd5, 8'd23, 8'd24:        o = -5'sd12;
			8'd6:                      o = -5'sd5;
			8'd7, 8'd16:               o = -5'sd2;
			8'd10, 8'd19:              o = -5'sd1;
			8'd11, 8'd13, 8'd14, 8'd15: o = -5'sd3;
			8'd12, 8'd20:              o = -5'sd4;
			8'd21:                     o = -5'sd7;
			8'd22:                     o = -5'sd10;
			default:                   o = '0;
		endcase
		return o;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/scheduled_hysteresis_thermostat_top.sv =====
// Scheduled hysteresis thermostat with a minimum relay switching interval.
// Accepts one item per clock while item_stall is low and returns one result per
// item through an input register, a state update stage and a stage that turns
// the remaining wait into whole seconds with a reciprocal multiply. The stages hand
// off through stall, so a stalled result does not block intake until all three are full.
// Configuration is taken on any cycle (cfg_ready is always high) and must only
// be written while no item is in flight. Uses sht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scheduled_hysteresis_thermostat_top #(
	parameter int TIMER_WIDTH    = sht_pkg::TIMER_WIDTH_DEF,
	parameter int TEMP_FRAC_BITS = sht_pkg::TEMP_FRAC_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             item_valid,
	output logic                                  item_stall,
	input  wire logic [2:0]                       mode,
	input  wire logic signed [sht_pkg::TEMP_W-1:0] temperature,
	input  wire logic [sht_pkg::HOUR_W-1:0]       hour,
	input  wire logic                             enable_value,
	output logic                                  result_valid,
	input  wire logic                             result_stall,
	output logic [3:0]                            status,
	output logic                                  relay_on,
	output logic [1:0]                            control_state,
	output logic                                  override_active,
	output logic                                  auto_enabled,
	output logic [sht_pkg::WAIT_W-1:0]            wait_seconds,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [sht_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [sht_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import sht_pkg::*;

	localparam int CMP_W = (TIMER_WIDTH > INTERVAL_W) ? TIMER_WIDTH : INTERVAL_W;
	localparam int PROD_W = INTERVAL_W + DIV_MUL_W;
	localparam logic signed [TEMP_W-1:0] BASE_RST =
		TEMP_W'(BASE_DEG * (1 << TEMP_FRAC_BITS));
	localparam logic signed [TEMP_W-1:0] ON_MARG_RST = TEMP_W'(1 << TEMP_FRAC_BITS);
	localparam logic signed [TEMP_W-1:0] SAFETY_RST =
		TEMP_W'(SAFETY_DEG * (1 << TEMP_FRAC_BITS));

	// configuration
	logic signed [TEMP_W-1:0] base_q, on_marg_q, off_marg_q, safety_q;
	logic [INTERVAL_W-1:0]    interval_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= BASE_RST;
			on_marg_q  <= ON_MARG_RST;
			off_marg_q <= '0;
			interval_q <= INTERVAL_W'(MIN_INTERVAL_RST);
			safety_q   <= SAFETY_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_BASE:     base_q     <= cfg_data[TEMP_W-1:0];
				CFG_ON_MARG:  on_marg_q  <= cfg_data[TEMP_W-1:0];
				CFG_OFF_MARG: off_marg_q <= cfg_data[TEMP_W-1:0];
				CFG_INTERVAL: interval_q <= cfg_data[INTERVAL_W-1:0];
				CFG_SAFETY:   safety_q   <= cfg_data[TEMP_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline handshake
	logic valid_s1, valid_s2, out_rdy, s2_rdy, s1_go, s1_rdy;

	assign out_rdy    = !result_valid || !result_stall;
	assign s2_rdy     = !valid_s2 || out_rdy;
	assign s1_go      = valid_s1 && s2_rdy;
	assign s1_rdy     = !valid_s1 || s2_rdy;
	assign item_stall = !s1_rdy;

	// input register
	logic [2:0]               mode_s1;
	logic signed [TEMP_W-1:0] temp_s1;
	logic [HOUR_W-1:0]        hour_s1;
	logic                     en_val_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_rdy) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && s1_rdy) begin
			mode_s1   <= mode;
			temp_s1   <= temperature;
			hour_s1   <= hour;
			en_val_s1 <= enable_value;
		end
	end

	// controller state
	heat_state_t            hs_q, hs_n, hs_mid;
	logic [TIMER_WIDTH-1:0] elapsed_q, elapsed_n;
	logic                   relay_q, relay_n, ovr_q, ovr_n, en_q, en_n;
	status_t                stat_n;

	logic signed [DIFF_W-1:0] offset_sc, diff, on_ext, off_ext;
	logic                     may_sw, off_group, want_on, may_sw_n;
	logic [CMP_W-1:0]         elapsed_ext, elapsed_n_ext, interval_ext, remain;

	assign offset_sc   = DIFF_W'(hour_offset(hour_s1)) <<< TEMP_FRAC_BITS;
	assign diff        = DIFF_W'(base_q) + offset_sc - DIFF_W'(temp_s1);
	assign on_ext      = DIFF_W'(on_marg_q);
	assign off_ext     = DIFF_W'(off_marg_q);
	assign elapsed_ext = CMP_W'(elapsed_q);
	assign interval_ext = CMP_W'(interval_q);
	assign may_sw      = elapsed_ext >= interval_ext;
	assign off_group   = (hs_q == HS_OFF) || (hs_q == HS_PEND_OFF);
	assign want_on     = off_group ? (diff >= on_ext) : (diff > off_ext);

	always_comb begin
		hs_n      = hs_q;
		elapsed_n = elapsed_q;
		relay_n   = relay_q;
		ovr_n     = ovr_q;
		en_n      = en_q;
		stat_n    = ST_NONE;
		hs_mid    = hs_q;
		case (mode_t'(mode_s1))
			MODE_TICK: begin
				if (elapsed_q != '1) begin
					elapsed_n = elapsed_q + 1'b1;
				end
			end
			MODE_TEMP: begin
				if (ovr_q) begin
					stat_n = (hs_q == HS_ON) ? ST_OVR_ON : ST_OVR_OFF;
				end else if (!en_q) begin
					stat_n = ST_NOT_EN;
				end else begin
					if (want_on && off_group) begin
						hs_mid = HS_PEND_ON;
					end else if (!want_on && !off_group) begin
						hs_mid = HS_PEND_OFF;
					end
					hs_n = hs_mid;
					if (may_sw && hs_mid == HS_PEND_ON) begin
						hs_n      = HS_ON;
						relay_n   = 1'b1;
						elapsed_n = '0;
						stat_n    = ST_TURNED_ON;
					end else if (may_sw && hs_mid == HS_PEND_OFF) begin
						hs_n      = HS_OFF;
						relay_n   = 1'b0;
						elapsed_n = '0;
						stat_n    = ST_TURNED_OFF;
					end
				end
			end
			MODE_TOGGLE: begin
				if (!ovr_q) begin
					if (temp_s1 <= safety_q) begin
						ovr_n     = 1'b1;
						hs_n      = HS_ON;
						relay_n   = 1'b1;
						elapsed_n = '0;
						stat_n    = ST_MANUAL_ON;
					end else begin
						stat_n = ST_REFUSED;
					end
				end else begin
					ovr_n     = 1'b0;
					hs_n      = HS_OFF;
					relay_n   = 1'b0;
					elapsed_n = '0;
					stat_n    = ST_MANUAL_OFF;
				end
			end
			MODE_CLEAR: begin
				ovr_n = 1'b0;
			end
			MODE_ENABLE: begin
				en_n = en_val_s1;
				if (!en_val_s1 && hs_q == HS_ON) begin
					hs_n      = HS_OFF;
					relay_n   = 1'b0;
					elapsed_n = '0;
				end
			end
			default: ;
		endcase
	end

	assign elapsed_n_ext = CMP_W'(elapsed_n);
	assign may_sw_n      = elapsed_n_ext >= interval_ext;
	assign remain        = interval_ext - elapsed_n_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_q      <= HS_OFF;
			elapsed_q <= '0;
			relay_q   <= 1'b0;
			ovr_q     <= 1'b0;
			en_q      <= 1'b1;
		end else if (s1_go) begin
			hs_q      <= hs_n;
			elapsed_q <= elapsed_n;
			relay_q   <= relay_n;
			ovr_q     <= ovr_n;
			en_q      <= en_n;
		end
	end

	// state update stage
	status_t               stat_s2;
	logic                  relay_s2, ovr_s2, en_s2;
	logic [1:0]            code_s2;
	logic [INTERVAL_W-1:0] remain_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_rdy) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			stat_s2   <= stat_n;
			relay_s2  <= relay_n;
			ovr_s2    <= ovr_n;
			en_s2     <= en_n;
			code_s2   <= state_code(hs_n);
			remain_s2 <= may_sw_n ? '0 : remain[INTERVAL_W-1:0];
		end
	end

	// result register, remaining milliseconds to whole seconds
	logic [PROD_W-1:0] prod;

	assign prod = PROD_W'(remain_s2) * PROD_W'(DIV_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_rdy) begin
			result_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && out_rdy) begin
			status          <= stat_s2;
			relay_on        <= relay_s2;
			control_state   <= code_s2;
			override_active <= ovr_s2;
			auto_enabled    <= en_s2;
			wait_seconds    <= prod[DIV_SHIFT +: WAIT_W];
		end
	end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// tb: self-checking testbench for scheduled_hysteresis_thermostat_top, with an
// in-line predictor, directed special cases, random traffic and output backpressure;
// depends on sht_pkg and the thermostat top level
`timescale 1ns / 1ps

module tb;
	import sht_pkg::*;

	localparam int DEG = 1 << TEMP_FRAC_BITS_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_LEN = 80;
	localparam int REPORT_MAX = 10;
	localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
	localparam logic [2:0] MODE_SPARE_LAST = 3'd7;
	localparam logic [2:0] CFG_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CFG_SPARE_LAST = 3'd7;

	typedef struct packed {
		logic [3:0] status;
		logic relay;
		logic [1:0] state;
		logic ovr;
		logic en;
		logic [WAIT_W-1:0] wait_s;
	} thermo_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [2:0] mode = '0;
	logic signed [TEMP_W-1:0] temperature = '0;
	logic [HOUR_W-1:0] hour = '0;
	logic enable_value = 1'b0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [3:0] status;
	logic relay_on;
	logic [1:0] control_state;
	logic override_active;
	logic auto_enabled;
	logic [WAIT_W-1:0] wait_seconds;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor state and settings
	logic [1:0] heat_code;
	logic [INTERVAL_W-1:0] elapsed_count;
	logic relay_now;
	logic override_now;
	logic enable_now;
	logic signed [TEMP_W-1:0] cfg_base;
	logic signed [TEMP_W-1:0] cfg_on_margin;
	logic signed [TEMP_W-1:0] cfg_off_margin;
	logic [INTERVAL_W-1:0] cfg_interval;
	logic signed [TEMP_W-1:0] cfg_safety;

	int sched_deg [24] = '{-15, -15, -15, -15, -12, -5, -2, 0, 0, -1, -3, -4,
		-3, -3, -3, -2, 0, 0, -1, -4, -7, -10, -12, -12};

	thermo_result_t expected_readings[$];
	int send_idle_pct = 13;
	int recv_idle_pct = 68;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int idle_cycles = 0;
	int items_sent = 0;
	int results_checked = 0;
	int cfg_writes = 0;
	int mismatches = 0;
	int status_hits [16];

	scheduled_hysteresis_thermostat_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.mode(mode),
		.temperature(temperature),
		.hour(hour),
		.enable_value(enable_value),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.status(status),
		.relay_on(relay_on),
		.control_state(control_state),
		.override_active(override_active),
		.auto_enabled(auto_enabled),
		.wait_seconds(wait_seconds),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic int sched_offset(logic [HOUR_W-1:0] h);
		if (h >= 1 && h <= 24)
			return sched_deg[h - 1];
		return 0;
	endfunction

	function automatic logic switch_allowed();
		return elapsed_count >= cfg_interval;
	endfunction

	function automatic void set_relay(logic on);
		heat_code = on ? CODE_ON : CODE_OFF;
		relay_now = on;
		elapsed_count = '0;
	endfunction

	function automatic status_t regulate(logic signed [TEMP_W-1:0] t, logic [HOUR_W-1:0] h);
		int diff;
		logic off_side;
		logic want_on;
		status_t st;
		st = ST_NONE;
		off_side = (heat_code == CODE_OFF) || (heat_code == CODE_PEND_OFF);
		diff = int'(cfg_base) + sched_offset(h) * DEG - int'(t);
		want_on = off_side ? (diff >= int'(cfg_on_margin)) : (diff > int'(cfg_off_margin));
		if (want_on && off_side) begin
			if (switch_allowed()) begin
				set_relay(1'b1);
				st = ST_TURNED_ON;
			end else begin
				heat_code = CODE_PEND_ON;
			end
		end else if (!want_on && !off_side) begin
			if (switch_allowed()) begin
				set_relay(1'b0);
				st = ST_TURNED_OFF;
			end else begin
				heat_code = CODE_PEND_OFF;
			end
		end
		if (heat_code == CODE_PEND_ON && switch_allowed()) begin
			set_relay(1'b1);
			st = ST_TURNED_ON;
		end else if (heat_code == CODE_PEND_OFF && switch_allowed()) begin
			set_relay(1'b0);
			st = ST_TURNED_OFF;
		end
		return st;
	endfunction

	function automatic thermo_result_t thermostat_step(logic [2:0] m, logic signed [TEMP_W-1:0] t,
			logic [HOUR_W-1:0] h, logic ev);
		thermo_result_t r;
		status_t st;
		st = ST_NONE;
		case (m)
			MODE_TICK: begin
				if (elapsed_count != '1)
					elapsed_count = elapsed_count + 1'b1;
			end
			MODE_TEMP: begin
				if (override_now)
					st = (heat_code == CODE_ON) ? ST_OVR_ON : ST_OVR_OFF;
				else if (!enable_now)
					st = ST_NOT_EN;
				else
					st = regulate(t, h);
			end
			MODE_TOGGLE: begin
				if (!override_now) begin
					if (t <= cfg_safety) begin
						override_now = 1'b1;
						set_relay(1'b1);
						st = ST_MANUAL_ON;
					end else begin
						st = ST_REFUSED;
					end
				end else begin
					override_now = 1'b0;
					set_relay(1'b0);
					st = ST_MANUAL_OFF;
				end
			end
			MODE_CLEAR: override_now = 1'b0;
			MODE_ENABLE: begin
				enable_now = ev;
				if (!ev && heat_code == CODE_ON)
					set_relay(1'b0);
			end
			default: ;
		endcase
		r.status = st;
		r.relay = relay_now;
		r.state = heat_code;
		r.ovr = override_now;
		r.en = enable_now;
		r.wait_s = '0;
		if (!switch_allowed())
			r.wait_s = WAIT_W'((cfg_interval - elapsed_count) / MS_PER_S);
		return r;
	endfunction

	task automatic check_result();
		thermo_result_t exp_r;
		thermo_result_t act_r;
		act_r = {status, relay_on, control_state, override_active, auto_enabled, wait_seconds};
		results_checked++;
		if (expected_readings.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("unexpected result transfer: %p", act_r);
		end else begin
			exp_r = expected_readings.pop_front();
			if (exp_r.status !== act_r.status || exp_r.relay !== act_r.relay ||
					exp_r.state !== act_r.state || exp_r.ovr !== act_r.ovr ||
					exp_r.en !== act_r.en || exp_r.wait_s !== act_r.wait_s) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("mismatch at %0t: expected %p, got %p", $realtime, exp_r, act_r);
			end
		end
	endtask

	// result side: checks and stalls, with a long hold-off on request
	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1 && !result_stall)
			check_result();
		if (hold_requests != hold_served) begin
			hold_served++;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_stall === 1'b0) || (result_valid === 1'b1 && !result_stall) ||
				(cfg_valid && cfg_ready === 1'b1)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", idle_cycles);
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_item(logic [2:0] m, logic signed [TEMP_W-1:0] t, logic [HOUR_W-1:0] h,
			logic ev);
		thermo_result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		mode <= m;
		temperature <= t;
		hour <= h;
		enable_value <= ev;
		@(posedge clk);
		while (item_stall !== 1'b0)
			@(posedge clk);
		r = thermostat_step(m, t, h, ev);
		status_hits[r.status]++;
		expected_readings.push_back(r);
		items_sent++;
	endtask

	task automatic send_random_item();
		int r;
		int d;
		logic [2:0] m;
		logic signed [TEMP_W-1:0] t;
		logic [HOUR_W-1:0] h;
		logic ev;
		r = $urandom_range(99);
		d = int'($urandom_range(136)) - 40;
		h = ($urandom_range(9) == 0) ? HOUR_W'($urandom) : HOUR_W'($urandom_range(24, 1));
		t = TEMP_W'($urandom);
		ev = 1'($urandom);
		m = MODE_TICK;
		if (r < 45) begin
			m = MODE_TICK;
		end else if (r < 83) begin
			m = MODE_TEMP;
			t = TEMP_W'(int'(cfg_base) + sched_offset(h) * DEG - d);
		end else if (r < 88) begin
			m = MODE_TOGGLE;
			t = TEMP_W'(int'(cfg_safety) + d / 2 - 14);
		end else if (r < 91) begin
			m = MODE_CLEAR;
		end else if (r < 95) begin
			m = MODE_ENABLE;
			ev = ($urandom_range(2) != 0);
		end else begin
			m = 3'($urandom);
			h = HOUR_W'($urandom);
		end
		send_item(m, t, h, ev);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		cfg_writes++;
		case (idx)
			CFG_BASE: cfg_base = d[TEMP_W-1:0];
			CFG_ON_MARG: cfg_on_margin = d[TEMP_W-1:0];
			CFG_OFF_MARG: cfg_off_margin = d[TEMP_W-1:0];
			CFG_INTERVAL: cfg_interval = d;
			CFG_SAFETY: cfg_safety = d[TEMP_W-1:0];
			default: ;
		endcase
	endtask

	// upper data bits of the 16-bit registers are don't-care, so they get noise
	task automatic configure(logic signed [TEMP_W-1:0] b, logic signed [TEMP_W-1:0] on_m,
			logic signed [TEMP_W-1:0] off_m, logic [INTERVAL_W-1:0] iv,
			logic signed [TEMP_W-1:0] sf);
		write_reg(CFG_BASE, {8'($urandom), b});
		write_reg(CFG_ON_MARG, {8'($urandom), on_m});
		write_reg(CFG_OFF_MARG, {8'($urandom), off_m});
		write_reg(CFG_INTERVAL, iv);
		write_reg(CFG_SAFETY, {8'($urandom), sf});
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_reset_state();
		send_item(MODE_TEMP, 16'sd0, 8'd0, 1'b0);
		send_item(MODE_TICK, 16'sd0, 8'd0, 1'b0);
		for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
			send_item(3'(m), TEMP_W'($urandom), HOUR_W'($urandom), 1'($urandom));
	endtask

	task automatic test_special_cases();
		drain();
		configure(16'sd1120, 16'sd16, 16'sd0, 24'd2, 16'sd1312);
		send_item(MODE_TICK, 16'sd0, 8'd0, 1'b0);
		send_item(MODE_TEMP, -16'sd32768, 8'd24, 1'b0);
		send_item(MODE_TEMP, 16'sd32767, 8'd25, 1'b0);
		send_item(MODE_TICK, 16'sd0, 8'd0, 1'b0);
		send_item(MODE_TICK, 16'sd0, 8'd0, 1'b0);
		send_item(MODE_TEMP, 16'sd32767, 8'd255, 1'b1);
		send_item(MODE_TOGGLE, 16'sd32767, 8'd0, 1'b0);
		send_item(MODE_TOGGLE, 16'sd1312, 8'd0, 1'b0);
		send_item(MODE_TEMP, 16'sd0, 8'd1, 1'b0);
		send_item(MODE_TOGGLE, 16'sd0, 8'd0, 1'b0);
		send_item(MODE_TOGGLE, -16'sd32768, 8'd0, 1'b0);
		send_item(MODE_ENABLE, 16'sd0, 8'd0, 1'b0);
		send_item(MODE_TEMP, 16'sd0, 8'd8, 1'b1);
		send_item(MODE_CLEAR, 16'sd0, 8'd0, 1'b0);
		send_item(MODE_TEMP, 16'sd0, 8'd8, 1'b1);
		send_item(MODE_ENABLE, 16'sd0, 8'd0, 1'b1);
		send_item(MODE_TEMP, -16'sd32768, 8'd12, 1'b0);
		send_item(MODE_ENABLE, 16'sd0, 8'd0, 1'b0);
		send_item(MODE_ENABLE, 16'sd0, 8'd0, 1'b1);
	endtask

	task automatic test_config_extremes();
		drain();
		configure(16'sd32767, -16'sd32768, 16'sd32767, 24'd0, -16'sd32768);
		repeat (30) send_random_item();
		drain();
		for (int i = CFG_SPARE_FIRST; i <= CFG_SPARE_LAST; i++)
			write_reg(3'(i), CFG_DATA_W'($urandom));
		configure(-16'sd32768, 16'sd32767, -16'sd32768, 24'hFFFFFF, 16'sd32767);
		repeat (30) send_random_item();
	endtask

	task automatic test_random_traffic(int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (4) begin
			drain();
			configure(TEMP_W'(int'($urandom_range(1600, 800))), TEMP_W'(int'($urandom_range(48))),
				TEMP_W'(int'($urandom_range(48)) - 24),
				($urandom_range(3) == 0) ? INTERVAL_W'($urandom_range(20000)) :
					INTERVAL_W'($urandom_range(40)),
				TEMP_W'(int'($urandom_range(1500, 900))));
			repeat (100) send_random_item();
		end
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		hold_requests++;
		repeat (40) send_random_item();
	endtask

	initial begin
		heat_code = CODE_OFF;
		elapsed_count = '0;
		relay_now = 1'b0;
		override_now = 1'b0;
		enable_now = 1'b1;
		cfg_base = TEMP_W'(BASE_DEG * DEG);
		cfg_on_margin = TEMP_W'(DEG);
		cfg_off_margin = '0;
		cfg_interval = INTERVAL_W'(MIN_INTERVAL_RST);
		cfg_safety = TEMP_W'(SAFETY_DEG * DEG);
		foreach (status_hits[i])
			status_hits[i] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_special_cases();
		test_config_extremes();
		test_random_traffic(13, 68);
		test_random_traffic(68, 13);
		test_random_traffic(0, 0);
		test_backpressure();
		drain();
		$display("%0d items, %0d results checked, %0d register writes, %0d mismatches",
			items_sent, results_checked, cfg_writes, mismatches);
		$display("turned on %0d, turned off %0d, manual on %0d, refused %0d, manual off %0d",
			status_hits[ST_TURNED_ON], status_hits[ST_TURNED_OFF], status_hits[ST_MANUAL_ON],
			status_hits[ST_REFUSED], status_hits[ST_MANUAL_OFF]);
		if (mismatches == 0 && expected_readings.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/sht_pkg.sv
rtl/scheduled_hysteresis_thermostat_top.sv
test/tb.sv
